// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Concurrent check that also runs while reset is high.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/swif_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swif_pkg;

   // Request commands
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_RENDER = 1'b1;

   // Default image size
   localparam int IMG_WIDTH_DEF  = 256;
   localparam int IMG_HEIGHT_DEF = 256;

   // Image store
   localparam int STORE_AW = 16;
   localparam int PIXEL_W  = 16;

   // Phase is taken modulo 1024
   localparam int PHASE_W = 10;

   typedef logic [PHASE_W-1:0]   phase_type;
   typedef logic signed [3:0]    wobble_type;
   typedef logic [STORE_AW-1:0]  addr_type;
   typedef logic [PIXEL_W-1:0]   pixel_type;

   // Rounded 4*sin(2*pi*p/1024), built from quarter-wave thresholds
   function automatic wobble_type sine_lookup(phase_type p);
      logic [8:0] h;
      logic [8:0] q;
      logic [2:0] lvl;
      h = p[8:0];
      q = (h <= 9'd256) ? h : 9'(10'd512 - {1'b0, h});
      if (q >= 9'd174) begin
         lvl = 3'd4;
      end else if (q >= 9'd111) begin
         lvl = 3'd3;
      end else if (q >= 9'd63) begin
         lvl = 3'd2;
      end else if (q >= 9'd21) begin
         lvl = 3'd1;
      end else begin
         lvl = 3'd0;
      end
      return p[9] ? -wobble_type'({1'b0, lvl}) : wobble_type'({1'b0, lvl});
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sine_wobble_image_fetch.sv =====
// Sine-wobble background fetch.
// Request channel (req_*): cmd selects a load (write req_load_pixel at
// req_load_index into the 64K x 16 image store, no response) or a render
// (screen x, y and frame number give one response pixel).
// Response channel (rsp_*): one rsp_pixel_out per render, in request order.
// A render displaces the screen position by four rounded sine terms, clamps
// it to the image and reads the stored pixel there.
// A render passes the request, address and response registers in order.
// Throughput: one request per cycle unless stalled, loads and renders mixed
// freely; the three registers (request, address, read data) each carry one
// request. Loads write the store when they leave the request register, so
// a later render always sees them.
// Reset clears the valid bits only; the store contents are undefined until
// written and need no clearing.
// A stalled response holds; requests keep flowing into empty stages behind
// it, and req_stall rises only once all three stages are full.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sine_wobble_image_fetch #(
   parameter int IMG_WIDTH  = swif_pkg::IMG_WIDTH_DEF,
   parameter int IMG_HEIGHT = swif_pkg::IMG_HEIGHT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_cmd,
   input  wire logic [15:0] req_load_index,
   input  wire logic [15:0] req_load_pixel,
   input  wire logic [8:0]  req_screen_x,
   input  wire logic [7:0]  req_screen_y,
   input  wire logic [9:0]  req_frame,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_pixel_out
);

   localparam int XW = (IMG_WIDTH  > 1) ? $clog2(IMG_WIDTH)  : 1;
   localparam int YW = (IMG_HEIGHT > 1) ? $clog2(IMG_HEIGHT) : 1;
   localparam logic signed [11:0] X_LIM = 12'(IMG_WIDTH);
   localparam logic signed [11:0] Y_LIM = 12'(IMG_HEIGHT);
   localparam logic [XW-1:0] X_MAX = XW'(IMG_WIDTH - 1);
   localparam logic [YW-1:0] Y_MAX = YW'(IMG_HEIGHT - 1);

   // Stage advance
   logic ld1, ld2, ld3;

   // Request register
   logic                 s1_valid_ff;
   logic                 s1_cmd_ff;
   swif_pkg::addr_type   s1_index_ff;
   swif_pkg::pixel_type  s1_pixel_ff;
   logic [8:0]           s1_x_ff;
   logic [7:0]           s1_y_ff;
   logic [9:0]           s1_frame_ff;

   // Address register
   logic                 s2_valid_ff;
   logic                 s2_valid_in;
   swif_pkg::addr_type   s2_addr_ff;
   swif_pkg::addr_type   s2_addr_in;

   // Response register
   logic                 rsp_valid_ff;
   swif_pkg::pixel_type  rsp_pixel_ff;

   // Image store
   swif_pkg::pixel_type  image_mem [2**swif_pkg::STORE_AW];

   // Displacement path
   swif_pkg::phase_type  ph_a, ph_b, ph_c, ph_d;
   swif_pkg::wobble_type w_a, w_b, w_c, w_d;
   logic signed [11:0]   src_x, src_y;
   logic [XW-1:0]        cx;
   logic [YW-1:0]        cy;
   logic                 store_wr;

   // Advance each stage when it is empty or the one ahead moves
   assign ld3 = !rsp_valid_ff || !rsp_stall;
   assign ld2 = !s2_valid_ff || ld3;
   assign ld1 = !s1_valid_ff || ld2;
   assign req_stall = !ld1;

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (ld1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1 && req_valid) begin
         s1_cmd_ff   <= req_cmd;
         s1_index_ff <= req_load_index;
         s1_pixel_ff <= req_load_pixel;
         s1_x_ff     <= req_screen_x;
         s1_y_ff     <= req_screen_y;
         s1_frame_ff <= req_frame;
      end
   end

   // Form the four phases modulo 1024
   assign ph_a = 10'(s1_frame_ff * 10'd24) + 10'(s1_x_ff * 10'd10);
   assign ph_b = 10'(s1_frame_ff * 10'd16) + 10'(s1_y_ff * 10'd8);
   assign ph_c = 10'(s1_frame_ff * 10'd18) + 10'(s1_x_ff * 10'd20);
   assign ph_d = 10'(s1_frame_ff * 10'd11) + 10'(s1_y_ff * 10'd24);

   assign w_a = swif_pkg::sine_lookup(ph_a);
   assign w_b = swif_pkg::sine_lookup(ph_b);
   assign w_c = swif_pkg::sine_lookup(ph_c);
   assign w_d = swif_pkg::sine_lookup(ph_d);

   // Displace and clamp to the image
   assign src_x = $signed({3'b000, s1_x_ff}) + 12'(w_b) + 12'(w_c);
   assign src_y = $signed({4'b0000, s1_y_ff}) + 12'(w_a) + 12'(w_d);

   always_comb begin
      if (src_x < 12'sd0) begin
         cx = '0;
      end else if (src_x >= X_LIM) begin
         cx = X_MAX;
      end else begin
         cx = src_x[XW-1:0];
      end
      if (src_y < 12'sd0) begin
         cy = '0;
      end else if (src_y >= Y_LIM) begin
         cy = Y_MAX;
      end else begin
         cy = src_y[YW-1:0];
      end
   end

   // Row-major index, wrapping modulo the store size
   assign s2_addr_in  = swif_pkg::STORE_AW'(32'(cy) * 32'(IMG_WIDTH) + 32'(cx));
   assign s2_valid_in = s1_valid_ff && (s1_cmd_ff == swif_pkg::CMD_RENDER);
   assign store_wr    = ld2 && s1_valid_ff && (s1_cmd_ff == swif_pkg::CMD_LOAD);

   // Advance renders into the address register; loads end here
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ld2) begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld2 && s2_valid_in) begin
         s2_addr_ff <= s2_addr_in;
      end
   end

   // Write loads into the store
   always_ff @(posedge clock) begin
      if (store_wr) begin
         image_mem[s1_index_ff] <= s1_pixel_ff;
      end
   end

   // Read the store into the response register
   always_ff @(posedge clock) begin
      if (ld3 && s2_valid_ff) begin
         rsp_pixel_ff <= image_mem[s2_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ld3) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;

   // Checks
   `ASSERT_CLK(a_stall_only_full, req_stall |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff), "request stalled with an empty stage")
   `ASSERT_CLK(a_load_no_rsp, (s1_valid_ff && s1_cmd_ff == swif_pkg::CMD_LOAD && ld2) |=> !s2_valid_ff, "load request produced a response")
   `ASSERT_CLK(a_render_moves, (s1_valid_ff && s1_cmd_ff == swif_pkg::CMD_RENDER && ld2) |=> s2_valid_ff, "render request lost before the store read")
   `ASSERT_CLK(a_read_lands, (s2_valid_ff && ld3) |=> rsp_valid_ff, "store read without a response")

endmodule

`default_nettype wire
